[rtl/sle_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants for the sequential list engine
// Command and status codes, field widths, and the control and status structs
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int VAL_W  = 32;
    localparam int POS_W  = 6;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_GET    = 3'd2,
        CMD_LOCATE = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_INDEX    = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Address sources for the element store.
    typedef enum logic [1:0] {
        ASEL_POS_M1 = 2'd0,
        ASEL_IDX    = 2'd1,
        ASEL_IDX_M1 = 2'd2
    } t_asel;

    // Start values for the walking index.
    typedef enum logic [1:0] {
        ISEL_COUNT = 2'd0,
        ISEL_POS   = 2'd1,
        ISEL_ZERO  = 2'd2
    } t_isel;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_asel   rd_sel;
        logic    wr_en;
        t_asel   wr_sel;
        logic    wr_from_in;
        logic    idx_load;
        t_isel   idx_sel;
        logic    idx_inc;
        logic    idx_dec;
        logic    take_vout;
        logic    take_found;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    cnt_clr;
        logic    stat_en;
        t_status stat_code;
    } t_dp_ctl;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             ins_bad;
        logic             rd_bad;
        logic             full;
        logic             idx_ge_pos;
        logic             idx_lt_cnt;
        logic             match;
    } t_dp_sts;

endpackage
`default_nettype wire

[rtl/sequential_list_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sequential_list_engine: ordered list with insert, delete, get, locate, clear
// Top level joining the command sequencer and the list datapath.
// ----------------------------------------------------------------------------
// Usage:
// An item is accepted at a rising edge where start is high and busy is low;
// it carries i_cmd, i_position and i_value_in. busy stays high until the
// result has been shown. The result appears on the o_ ports for exactly one
// cycle with o_valid high; the receiver cannot stall it, so it must take it
// in that cycle. The next item can be accepted in the cycle after o_valid.
// Insert moves the elements at and after the position up one entry at a time,
// delete moves the elements after the position down; each moved entry is read
// and then written back through the element memory. Locate compares the stored
// elements in order from the first and stops at the first match or at the end
// of the list.
// Reset (i_rst_n low at a clock edge) returns the sequencer to idle and
// empties the list; the element memory itself is not cleared.
// ----------------------------------------------------------------------------
module sequential_list_engine import sle_pkg::*; #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [CMD_W-1:0] i_cmd,
    input  wire logic [POS_W-1:0] i_position,
    input  wire logic [VAL_W-1:0] i_value_in,
    output logic                  o_valid,
    output logic [STAT_W-1:0]     o_status,
    output logic [VAL_W-1:0]      o_value_out,
    output logic [POS_W-1:0]      o_found_position,
    output logic [POS_W-1:0]      o_list_length,
    output logic                  o_is_empty
);

    t_dp_ctl ctl;
    t_dp_sts sts;

    sle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    sle_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .i_cmd            (i_cmd),
        .i_position       (i_position),
        .i_value_in       (i_value_in),
        .o_sts            (sts),
        .o_status         (o_status),
        .o_value_out      (o_value_out),
        .o_found_position (o_found_position),
        .o_list_length    (o_list_length),
        .o_is_empty       (o_is_empty)
    );

endmodule
`default_nettype wire

[rtl/sle_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sle_ram: generic single-write, single-read memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

[rtl/sle_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sle_ctrl: command sequencer of the sequential list engine
// Checks each command, then walks the element store one entry per step to
// shift, fetch or search, and raises the result strobe for one cycle.
// ----------------------------------------------------------------------------
module sle_ctrl import sle_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_dp_sts i_sts,
    output t_dp_ctl      o_ctl,
    output logic         o_busy,
    output logic         o_valid
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_CHECK    = 11'b000_0000_0010,
        S_FETCH    = 11'b000_0000_0100,
        S_TAKE     = 11'b000_0000_1000,
        S_MOVE_CHK = 11'b000_0001_0000,
        S_MOVE_RD  = 11'b000_0010_0000,
        S_MOVE_WR  = 11'b000_0100_0000,
        S_PUT      = 11'b000_1000_0000,
        S_SCAN_RD  = 11'b001_0000_0000,
        S_SCAN_CMP = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   is_ins;

    assign is_ins  = (i_sts.cmd == CMD_INSERT);
    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

    always_comb begin
        n_state          = r_state;
        o_ctl.load       = 1'b0;
        o_ctl.rd_en      = 1'b0;
        o_ctl.rd_sel     = ASEL_IDX;
        o_ctl.wr_en      = 1'b0;
        o_ctl.wr_sel     = ASEL_IDX;
        o_ctl.wr_from_in = 1'b0;
        o_ctl.idx_load   = 1'b0;
        o_ctl.idx_sel    = ISEL_ZERO;
        o_ctl.idx_inc    = 1'b0;
        o_ctl.idx_dec    = 1'b0;
        o_ctl.take_vout  = 1'b0;
        o_ctl.take_found = 1'b0;
        o_ctl.cnt_inc    = 1'b0;
        o_ctl.cnt_dec    = 1'b0;
        o_ctl.cnt_clr    = 1'b0;
        o_ctl.stat_en    = 1'b0;
        o_ctl.stat_code  = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                case (i_sts.cmd)
                    CMD_INSERT: begin
                        if (i_sts.ins_bad) begin
                            o_ctl.stat_en   = 1'b1;
                            o_ctl.stat_code = ST_INDEX;
                            n_state         = S_DONE;
                        end else if (i_sts.full) begin
                            o_ctl.stat_en   = 1'b1;
                            o_ctl.stat_code = ST_OVERFLOW;
                            n_state         = S_DONE;
                        end else begin
                            o_ctl.idx_load = 1'b1;
                            o_ctl.idx_sel  = ISEL_COUNT;
                            n_state        = S_MOVE_CHK;
                        end
                    end
                    CMD_DELETE, CMD_GET: begin
                        if (i_sts.rd_bad) begin
                            o_ctl.stat_en   = 1'b1;
                            o_ctl.stat_code = ST_INDEX;
                            n_state         = S_DONE;
                        end else begin
                            n_state = S_FETCH;
                        end
                    end
                    CMD_LOCATE: begin
                        o_ctl.idx_load = 1'b1;
                        o_ctl.idx_sel  = ISEL_ZERO;
                        n_state        = S_SCAN_RD;
                    end
                    CMD_CLEAR: begin
                        o_ctl.cnt_clr = 1'b1;
                        n_state       = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_FETCH: begin
                o_ctl.rd_en  = 1'b1;
                o_ctl.rd_sel = ASEL_POS_M1;
                n_state      = S_TAKE;
            end
            S_TAKE: begin
                o_ctl.take_vout = 1'b1;
                o_ctl.idx_load  = 1'b1;
                o_ctl.idx_sel   = ISEL_POS;
                n_state         = (i_sts.cmd == CMD_DELETE) ? S_MOVE_CHK : S_DONE;
            end
            S_MOVE_CHK: begin
                // Insert walks down from the end, delete walks up towards it.
                if (is_ins ? i_sts.idx_ge_pos : i_sts.idx_lt_cnt) begin
                    n_state = S_MOVE_RD;
                end else if (is_ins) begin
                    n_state = S_PUT;
                end else begin
                    o_ctl.cnt_dec = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_MOVE_RD: begin
                o_ctl.rd_en  = 1'b1;
                o_ctl.rd_sel = is_ins ? ASEL_IDX_M1 : ASEL_IDX;
                n_state      = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                o_ctl.wr_en   = 1'b1;
                o_ctl.wr_sel  = is_ins ? ASEL_IDX : ASEL_IDX_M1;
                o_ctl.idx_dec = is_ins;
                o_ctl.idx_inc = !is_ins;
                n_state       = S_MOVE_CHK;
            end
            S_PUT: begin
                o_ctl.wr_en      = 1'b1;
                o_ctl.wr_sel     = ASEL_POS_M1;
                o_ctl.wr_from_in = 1'b1;
                o_ctl.cnt_inc    = 1'b1;
                n_state          = S_DONE;
            end
            S_SCAN_RD: begin
                if (i_sts.idx_lt_cnt) begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = ASEL_IDX;
                    n_state      = S_SCAN_CMP;
                end else begin
                    o_ctl.stat_en   = 1'b1;
                    o_ctl.stat_code = ST_NOTFOUND;
                    n_state         = S_DONE;
                end
            end
            S_SCAN_CMP: begin
                if (i_sts.match) begin
                    o_ctl.take_found = 1'b1;
                    n_state          = S_DONE;
                end else begin
                    o_ctl.idx_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

[rtl/sle_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sle_dpath: datapath of the sequential list engine
// Holds the command, the element store, the list length, the walking index
// and the result registers, and reports range checks and compares.
// ----------------------------------------------------------------------------
module sle_dpath import sle_pkg::*; #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_ctl          i_ctl,
    input  wire logic [CMD_W-1:0] i_cmd,
    input  wire logic [POS_W-1:0] i_position,
    input  wire logic [VAL_W-1:0] i_value_in,
    output t_dp_sts               o_sts,
    output logic [STAT_W-1:0]     o_status,
    output logic [VAL_W-1:0]      o_value_out,
    output logic [POS_W-1:0]      o_found_position,
    output logic [POS_W-1:0]      o_list_length,
    output logic                  o_is_empty
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int WW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [CMD_W-1:0]      r_cmd;
    logic [WW-1:0]         r_pos;
    logic [DATA_WIDTH-1:0] r_val;
    logic [CW-1:0]         r_idx,   n_idx;
    logic [CW-1:0]         r_count, n_count;
    t_status               r_status, n_status;
    logic [DATA_WIDTH-1:0] r_vout,  n_vout;
    logic [POS_W-1:0]      r_found, n_found;

    logic [CW-1:0]         idx_m1;
    logic [CW-1:0]         idx_p1;
    logic [WW-1:0]         pos_m1;
    logic [WW-1:0]         cnt_w;
    logic [WW-1:0]         idx_w;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] rd_data;

    assign idx_m1 = r_idx - CW'(1);
    assign idx_p1 = r_idx + CW'(1);
    assign pos_m1 = r_pos - WW'(1);
    assign cnt_w  = WW'(r_count);
    assign idx_w  = WW'(r_idx);

    always_comb begin
        case (i_ctl.rd_sel)
            ASEL_POS_M1: rd_addr = pos_m1[AW-1:0];
            ASEL_IDX_M1: rd_addr = idx_m1[AW-1:0];
            default:     rd_addr = r_idx[AW-1:0];
        endcase
        case (i_ctl.wr_sel)
            ASEL_POS_M1: wr_addr = pos_m1[AW-1:0];
            ASEL_IDX_M1: wr_addr = idx_m1[AW-1:0];
            default:     wr_addr = r_idx[AW-1:0];
        endcase
    end

    assign wr_data = i_ctl.wr_from_in ? r_val : rd_data;

    sle_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_ctl.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_sts.cmd        = r_cmd;
    assign o_sts.ins_bad    = (r_pos == '0) || (r_pos > cnt_w + WW'(1));
    assign o_sts.rd_bad     = (r_pos == '0) || (r_pos > cnt_w);
    assign o_sts.full       = (r_count == CW'(CAPACITY));
    assign o_sts.idx_ge_pos = (idx_w >= r_pos);
    assign o_sts.idx_lt_cnt = (r_idx < r_count);
    assign o_sts.match      = (rd_data == r_val);

    always_comb begin
        n_idx = r_idx;
        if (i_ctl.idx_load) begin
            case (i_ctl.idx_sel)
                ISEL_COUNT: n_idx = r_count;
                ISEL_POS:   n_idx = CW'(r_pos);
                default:    n_idx = '0;
            endcase
        end else if (i_ctl.idx_inc) begin
            n_idx = idx_p1;
        end else if (i_ctl.idx_dec) begin
            n_idx = idx_m1;
        end

        n_count = r_count;
        if (i_ctl.cnt_clr) begin
            n_count = '0;
        end else if (i_ctl.cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_ctl.cnt_dec) begin
            n_count = r_count - CW'(1);
        end

        n_status = r_status;
        n_vout   = r_vout;
        n_found  = r_found;
        if (i_ctl.load) begin
            n_status = ST_OK;
            n_vout   = '0;
            n_found  = '0;
        end else begin
            if (i_ctl.stat_en) begin
                n_status = i_ctl.stat_code;
            end
            if (i_ctl.take_vout) begin
                n_vout = rd_data;
            end
            if (i_ctl.take_found) begin
                n_found = POS_W'(idx_p1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_pos <= WW'(i_position);
            r_val <= DATA_WIDTH'(i_value_in);
        end
        r_idx    <= n_idx;
        r_status <= n_status;
        r_vout   <= n_vout;
        r_found  <= n_found;
    end

    assign o_status         = r_status;
    assign o_value_out      = VAL_W'(r_vout);
    assign o_found_position = r_found;
    assign o_list_length    = POS_W'(r_count);
    assign o_is_empty       = (r_count == '0);

endmodule
`default_nettype wire
